// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the line walker RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property check, disabled while reset is asserted (active low).
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// A condition that must never hold.
`define ASSERT_NEVER(label, clk, rstn, cond, msg) \
    `ASSERT_CLK(label, clk, rstn, !(cond), msg)

`endif

// ----- rtl/lvw_pkg.sv -----
// Shared types and constants of the 3D line voxel walker.
`timescale 1ns / 1ps

package lvw_pkg;

    localparam int NUM_AXES    = 3;
    localparam int MAX_RESULTS = 64;
    localparam int CNT_W       = $clog2(MAX_RESULTS);

    localparam int AXIS_X = 0;
    localparam int AXIS_Y = 1;
    localparam int AXIS_Z = 2;

    // Per-axis control for the step unit: which axis drives, which axes count up.
    typedef struct packed {
        logic [NUM_AXES-1:0] drv_onehot;
        logic [NUM_AXES-1:0] dir_up;
    } axis_ctrl_t;

endpackage

// ----- rtl/line_voxel_walker_3d.sv -----
// Top level of the 3D Bresenham line voxel walker.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Accepts one transaction holding a start and an end voxel and returns the
// voxels of the 3D Bresenham line between them, start first and end last,
// one result transaction per point, with m_run_end set on the final one.
// The driving axis is the one with the largest delta, ties going to X, then
// Y. After an input transaction is taken the block passes through the set-up
// states ST_DELTA (deltas and directions) and ST_INIT (driving axis and initial
// error terms) and then offers one point per cycle while m_ready is high;
// every point after the start is made by the single shared step unit that
// advances all axes from the current one. s_ready is high only while the
// block is idle. Runs longer than 64 points (possible when COORD_BITS exceeds
// 6) are cut after 64 points, with the flag on the 64th. There are no
// configuration registers and no memories.
module line_voxel_walker_3d #(
    parameter int COORD_BITS = 6
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [COORD_BITS-1:0] s_start_x,
    input  logic [COORD_BITS-1:0] s_start_y,
    input  logic [COORD_BITS-1:0] s_start_z,
    input  logic [COORD_BITS-1:0] s_end_x,
    input  logic [COORD_BITS-1:0] s_end_y,
    input  logic [COORD_BITS-1:0] s_end_z,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [COORD_BITS-1:0] m_point_x,
    output logic [COORD_BITS-1:0] m_point_y,
    output logic [COORD_BITS-1:0] m_point_z,
    output logic                  m_run_end
);

    localparam int NA    = lvw_pkg::NUM_AXES;
    localparam int ERR_W = COORD_BITS + 3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DELTA,
        ST_INIT,
        ST_RUN
    } state_t;

    state_t state_reg;

    // Working registers of the walk. pos_reg holds the start voxel until the
    // walk begins and the current point afterwards.
    logic [COORD_BITS-1:0]   pos_reg  [NA];
    logic [COORD_BITS-1:0]   end_reg  [NA];
    logic [COORD_BITS-1:0]   dlt_reg  [NA];
    logic signed [ERR_W-1:0] err_reg  [NA];
    logic [COORD_BITS-1:0]   dlt_drv_reg;
    logic [COORD_BITS-1:0]   rem_reg;
    logic [lvw_pkg::CNT_W-1:0] cnt_reg;
    lvw_pkg::axis_ctrl_t     ctrl_reg;

    logic [COORD_BITS-1:0]   pos_next [NA];
    logic signed [ERR_W-1:0] err_next [NA];
    logic [NA-1:0]           drv_sel;
    logic [COORD_BITS-1:0]   dlt_drv_sel;
    logic                    last_pt;
    logic                    in_acc;
    logic                    out_acc;

    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = (state_reg == ST_RUN);
    assign in_acc   = s_valid && s_ready;
    assign out_acc  = m_valid && m_ready;

    assign m_point_x = pos_reg[lvw_pkg::AXIS_X];
    assign m_point_y = pos_reg[lvw_pkg::AXIS_Y];
    assign m_point_z = pos_reg[lvw_pkg::AXIS_Z];

    // The final point is reached when no driving steps remain, or when the
    // run has hit its length limit.
    assign last_pt      = (rem_reg == '0) ||
                          (cnt_reg == lvw_pkg::CNT_W'(lvw_pkg::MAX_RESULTS - 1));
    assign m_run_end    = last_pt;

    // Driving axis choice: X wins ties, then Y.
    always_comb begin
        drv_sel = '0;
        if (dlt_reg[lvw_pkg::AXIS_X] >= dlt_reg[lvw_pkg::AXIS_Y] &&
            dlt_reg[lvw_pkg::AXIS_X] >= dlt_reg[lvw_pkg::AXIS_Z]) begin
            drv_sel[lvw_pkg::AXIS_X] = 1'b1;
        end else if (dlt_reg[lvw_pkg::AXIS_Y] >= dlt_reg[lvw_pkg::AXIS_Z]) begin
            drv_sel[lvw_pkg::AXIS_Y] = 1'b1;
        end else begin
            drv_sel[lvw_pkg::AXIS_Z] = 1'b1;
        end
        dlt_drv_sel = drv_sel[lvw_pkg::AXIS_X] ? dlt_reg[lvw_pkg::AXIS_X] :
                      drv_sel[lvw_pkg::AXIS_Y] ? dlt_reg[lvw_pkg::AXIS_Y] :
                                                 dlt_reg[lvw_pkg::AXIS_Z];
    end

    lvw_step_unit #(
        .COORD_BITS (COORD_BITS),
        .ERR_W      (ERR_W)
    ) u_step (
        .ctrl     (ctrl_reg),
        .pos      (pos_reg),
        .dlt      (dlt_reg),
        .dlt_drv  (dlt_drv_reg),
        .err      (err_reg),
        .pos_next (pos_next),
        .err_next (err_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (in_acc) begin
                        pos_reg[lvw_pkg::AXIS_X] <= s_start_x;
                        pos_reg[lvw_pkg::AXIS_Y] <= s_start_y;
                        pos_reg[lvw_pkg::AXIS_Z] <= s_start_z;
                        end_reg[lvw_pkg::AXIS_X] <= s_end_x;
                        end_reg[lvw_pkg::AXIS_Y] <= s_end_y;
                        end_reg[lvw_pkg::AXIS_Z] <= s_end_z;
                        state_reg <= ST_DELTA;
                    end
                end
                ST_DELTA: begin
                    // Absolute delta and direction of each axis.
                    for (int i = 0; i < NA; i++) begin
                        ctrl_reg.dir_up[i] <= end_reg[i] > pos_reg[i];
                        dlt_reg[i] <= (end_reg[i] > pos_reg[i]) ? end_reg[i] - pos_reg[i]
                                                                : pos_reg[i] - end_reg[i];
                    end
                    state_reg <= ST_INIT;
                end
                ST_INIT: begin
                    // Error terms start at twice the axis delta minus the driving delta.
                    for (int i = 0; i < NA; i++) begin
                        err_reg[i] <= $signed(ERR_W'({dlt_reg[i], 1'b0})) -
                                      $signed(ERR_W'(dlt_drv_sel));
                    end
                    ctrl_reg.drv_onehot <= drv_sel;
                    dlt_drv_reg         <= dlt_drv_sel;
                    rem_reg             <= dlt_drv_sel;
                    cnt_reg             <= '0;
                    state_reg           <= ST_RUN;
                end
                ST_RUN: begin
                    if (out_acc) begin
                        if (last_pt) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            pos_reg <= pos_next;
                            err_reg <= err_next;
                            rem_reg <= rem_reg - COORD_BITS'(1);
                            cnt_reg <= cnt_reg + lvw_pkg::CNT_W'(1);
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    `ASSERT_NEVER(a_busy_excl, aclk, aresetn, s_ready && m_valid, "ready while a point is offered")
    `ASSERT_CLK(a_setup_gap, aclk, aresetn, in_acc |=> !m_valid && !s_ready, "no set-up after accept")
    `ASSERT_CLK(a_run_cont, aclk, aresetn, out_acc && !last_pt |=> m_valid, "run broken before last point")
    `ASSERT_CLK(a_run_done, aclk, aresetn, out_acc && last_pt |=> s_ready, "not idle after last point")

endmodule

// ----- rtl/lvw_step_unit.sv -----
// Shared step unit: advances all three axes and their error terms by one point.
`timescale 1ns / 1ps

module lvw_step_unit #(
    parameter int COORD_BITS = 6,
    parameter int ERR_W      = COORD_BITS + 3
) (
    input  lvw_pkg::axis_ctrl_t    ctrl,
    input  logic [COORD_BITS-1:0]  pos      [lvw_pkg::NUM_AXES],
    input  logic [COORD_BITS-1:0]  dlt      [lvw_pkg::NUM_AXES],
    input  logic [COORD_BITS-1:0]  dlt_drv,
    input  logic signed [ERR_W-1:0] err     [lvw_pkg::NUM_AXES],
    output logic [COORD_BITS-1:0]  pos_next [lvw_pkg::NUM_AXES],
    output logic signed [ERR_W-1:0] err_next [lvw_pkg::NUM_AXES]
);

    logic signed [ERR_W-1:0] two_drv;

    assign two_drv = $signed(ERR_W'({dlt_drv, 1'b0}));

    for (genvar i = 0; i < lvw_pkg::NUM_AXES; i++) begin : g_lane
        logic                    sec_step;
        logic                    step_en;
        logic signed [ERR_W-1:0] two_dlt;
        logic signed [ERR_W-1:0] err_adj;

        // A secondary axis steps when its error term is non-negative.
        assign sec_step = !ctrl.drv_onehot[i] && !err[i][ERR_W-1];
        assign step_en  = ctrl.drv_onehot[i] || sec_step;
        assign two_dlt  = $signed(ERR_W'({dlt[i], 1'b0}));
        assign err_adj  = sec_step ? (err[i] - two_drv) : err[i];

        assign pos_next[i] = !step_en ? pos[i] :
                             ctrl.dir_up[i] ? pos[i] + COORD_BITS'(1) : pos[i] - COORD_BITS'(1);
        assign err_next[i] = err_adj + two_dlt;
    end

endmodule

// ----- sim/tb_line_voxel_walker_3d.sv -----
// Self-checking testbench for the 3D Bresenham line voxel walker.
`timescale 1ns / 1ps

module tb_line_voxel_walker_3d;

    localparam int COORD_BITS = 6;
    localparam int CMAX       = (1 << COORD_BITS) - 1;
    localparam int N_RANDOM   = 450;
    // The slowest legal run is roughly 470 lines of 64 points, each point
    // waiting out the longest sink stall; LIMIT allows far more than that.
    localparam int LIMIT      = 3_000_000;

    // One line request: start and end voxel, indexed by axis.
    typedef struct packed {
        logic [lvw_pkg::NUM_AXES-1:0][COORD_BITS-1:0] from;
        logic [lvw_pkg::NUM_AXES-1:0][COORD_BITS-1:0] to;
    } line_req_t;

    // One voxel of the walked line as it should appear on the result side.
    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [COORD_BITS-1:0] z;
        logic                  last;
    } voxel_pt_t;

    logic                  aclk    = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [COORD_BITS-1:0] s_start_x = '0;
    logic [COORD_BITS-1:0] s_start_y = '0;
    logic [COORD_BITS-1:0] s_start_z = '0;
    logic [COORD_BITS-1:0] s_end_x   = '0;
    logic [COORD_BITS-1:0] s_end_y   = '0;
    logic [COORD_BITS-1:0] s_end_z   = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [COORD_BITS-1:0] m_point_x;
    logic [COORD_BITS-1:0] m_point_y;
    logic [COORD_BITS-1:0] m_point_z;
    logic                  m_run_end;

    // Lines still to be offered, and voxels predicted but not yet seen.
    line_req_t pending_lines[$];
    voxel_pt_t pending_points[$];

    int  n_lines_total = 0;
    int  n_accepted    = 0;
    int  n_errors      = 0;
    int  cycle_cnt     = 0;
    int  src_gap       = 0;
    int  snk_gap       = 0;
    // When clear, neither side starts a new burst of idle cycles.
    bit  idle_en       = 1'b1;

    line_voxel_walker_3d #(
        .COORD_BITS(COORD_BITS)
    ) u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_start_x   (s_start_x),
        .s_start_y   (s_start_y),
        .s_start_z   (s_start_z),
        .s_end_x     (s_end_x),
        .s_end_y     (s_end_y),
        .s_end_z     (s_end_z),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_point_x   (m_point_x),
        .m_point_y   (m_point_y),
        .m_point_z   (m_point_z),
        .m_run_end   (m_run_end)
    );

    always #2 aclk = ~aclk;

    // Walks the line from the start to the end voxel and queues every voxel
    // it visits. The driving axis has the largest delta, with ties resolved
    // in favour of X and then Y. Each of the other two axes carries a signed
    // error term; it steps whenever its term is non-negative.
    function automatic void trace_line(input line_req_t req);
        int pos[lvw_pkg::NUM_AXES];
        int dlt[lvw_pkg::NUM_AXES];
        int dir[lvw_pkg::NUM_AXES];
        int err[lvw_pkg::NUM_AXES];
        int drv;
        int n;
        bit is_last;
        voxel_pt_t pt;
        for (int i = 0; i < lvw_pkg::NUM_AXES; i++) begin
            pos[i] = req.from[i];
            dlt[i] = (req.to[i] > req.from[i]) ? req.to[i] - req.from[i]
                                               : req.from[i] - req.to[i];
            dir[i] = (req.to[i] > req.from[i]) ? 1 : -1;
        end
        if (dlt[lvw_pkg::AXIS_X] >= dlt[lvw_pkg::AXIS_Y] &&
            dlt[lvw_pkg::AXIS_X] >= dlt[lvw_pkg::AXIS_Z])
            drv = lvw_pkg::AXIS_X;
        else if (dlt[lvw_pkg::AXIS_Y] >= dlt[lvw_pkg::AXIS_Z])
            drv = lvw_pkg::AXIS_Y;
        else
            drv = lvw_pkg::AXIS_Z;
        for (int i = 0; i < lvw_pkg::NUM_AXES; i++)
            err[i] = 2 * dlt[i] - dlt[drv];
        n = 0;
        forever begin
            // A run that would exceed the result budget is cut short, with
            // the flag moved onto the final voxel that is still emitted.
            is_last = (n == dlt[drv]) || (n == lvw_pkg::MAX_RESULTS - 1);
            pt.x    = pos[lvw_pkg::AXIS_X][COORD_BITS-1:0];
            pt.y    = pos[lvw_pkg::AXIS_Y][COORD_BITS-1:0];
            pt.z    = pos[lvw_pkg::AXIS_Z][COORD_BITS-1:0];
            pt.last = is_last;
            pending_points.insert(pending_points.size(), pt);
            n++;
            if (is_last)
                break;
            pos[drv] += dir[drv];
            for (int i = 0; i < lvw_pkg::NUM_AXES; i++) begin
                if (i != drv) begin
                    if (err[i] >= 0) begin
                        pos[i] += dir[i];
                        err[i] -= 2 * dlt[drv];
                    end
                    err[i] += 2 * dlt[i];
                end
            end
        end
    endfunction

    function automatic void queue_line(input int sx, input int sy, input int sz,
                                       input int ex, input int ey, input int ez);
        line_req_t req;
        req.from[lvw_pkg::AXIS_X] = sx[COORD_BITS-1:0];
        req.from[lvw_pkg::AXIS_Y] = sy[COORD_BITS-1:0];
        req.from[lvw_pkg::AXIS_Z] = sz[COORD_BITS-1:0];
        req.to[lvw_pkg::AXIS_X]   = ex[COORD_BITS-1:0];
        req.to[lvw_pkg::AXIS_Y]   = ey[COORD_BITS-1:0];
        req.to[lvw_pkg::AXIS_Z]   = ez[COORD_BITS-1:0];
        pending_lines.insert(pending_lines.size(), req);
        n_lines_total++;
    endfunction

    // Source side. A transaction is held until it is taken; the prediction
    // is made at the edge where it is accepted, from the values on the port.
    always @(posedge aclk) begin
        line_req_t req;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!(s_valid && !s_ready)) begin
            if (s_valid) begin
                req.from[lvw_pkg::AXIS_X] = s_start_x;
                req.from[lvw_pkg::AXIS_Y] = s_start_y;
                req.from[lvw_pkg::AXIS_Z] = s_start_z;
                req.to[lvw_pkg::AXIS_X]   = s_end_x;
                req.to[lvw_pkg::AXIS_Y]   = s_end_y;
                req.to[lvw_pkg::AXIS_Z]   = s_end_z;
                trace_line(req);
                n_accepted++;
            end
            if (src_gap > 0) begin
                src_gap--;
                s_valid <= 1'b0;
            end else if (idle_en && $urandom_range(0, 7) == 0) begin
                // Start a burst of idle cycles; this cycle is the first one.
                src_gap = $urandom_range(1, 19) - 1;
                s_valid <= 1'b0;
            end else if (pending_lines.size() > 0) begin
                req = pending_lines.pop_front();
                s_start_x <= req.from[lvw_pkg::AXIS_X];
                s_start_y <= req.from[lvw_pkg::AXIS_Y];
                s_start_z <= req.from[lvw_pkg::AXIS_Z];
                s_end_x   <= req.to[lvw_pkg::AXIS_X];
                s_end_y   <= req.to[lvw_pkg::AXIS_Y];
                s_end_z   <= req.to[lvw_pkg::AXIS_Z];
                s_valid   <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Result side. Each accepted voxel is compared with the oldest one
    // predicted; m_ready is stalled in random bursts while idling is enabled.
    always @(posedge aclk) begin
        voxel_pt_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (pending_points.size() == 0) begin
                    $error("unexpected result transaction: x=%0d y=%0d z=%0d last=%0b",
                           m_point_x, m_point_y, m_point_z, m_run_end);
                    n_errors++;
                end else begin
                    want = pending_points.pop_front();
                    if (m_point_x !== want.x) begin
                        $error("point_x: expected %0d, got %0d", want.x, m_point_x);
                        n_errors++;
                    end
                    if (m_point_y !== want.y) begin
                        $error("point_y: expected %0d, got %0d", want.y, m_point_y);
                        n_errors++;
                    end
                    if (m_point_z !== want.z) begin
                        $error("point_z: expected %0d, got %0d", want.z, m_point_z);
                        n_errors++;
                    end
                    if (m_run_end !== want.last) begin
                        $error("run_end: expected %0b, got %0b", want.last,
                               m_run_end);
                        n_errors++;
                    end
                end
            end
            if (snk_gap > 0) begin
                snk_gap--;
                m_ready <= 1'b0;
            end else if (idle_en && $urandom_range(0, 7) == 0) begin
                snk_gap = $urandom_range(1, 19) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog: a hung handshake must not keep the run going for ever.
    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt >= LIMIT) begin
            $display("tb_line_voxel_walker_3d: FAIL");
            $finish;
        end
    end

    initial begin
        int kind;
        int d;
        int lo;
        int off;
        int mask;
        int st[lvw_pkg::NUM_AXES];
        int en[lvw_pkg::NUM_AXES];

        // Directed lines: equal endpoints at both corners, the full
        // diagonals, single-axis lines in each direction, every kind of tie
        // for the driving axis, each axis driving, and alternating bit
        // patterns so that every coordinate bit is exercised both ways.
        queue_line(0, 0, 0, 0, 0, 0);
        queue_line(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX);
        queue_line(0, 0, 0, CMAX, CMAX, CMAX);
        queue_line(CMAX, CMAX, CMAX, 0, 0, 0);
        queue_line(0, 0, 0, CMAX, 0, 0);
        queue_line(0, CMAX, 0, 0, 0, 0);
        queue_line(5, 5, 0, 5, 5, CMAX);
        queue_line(0, 0, 0, 20, 20, 5);
        queue_line(10, 0, 40, 40, 7, 10);
        queue_line(0, CMAX, CMAX, 9, 0, 0);
        queue_line(30, 0, 2, 20, 50, 7);
        queue_line(1, 2, 0, 4, 3, 60);
        queue_line(CMAX, 0, CMAX, 0, CMAX, 0);
        queue_line(0, 0, 0, 1, 1, 1);
        queue_line(32, 32, 32, 31, 33, 32);
        queue_line(0, 31, CMAX, CMAX, 32, 0);
        queue_line(42, 21, 0, 21, 42, CMAX);
        queue_line(0, 0, 0, CMAX, 1, 62);
        queue_line(10, 10, 10, 10, 10, 11);
        queue_line(0, 0, 0, 1, 0, 0);

        // Random lines: most are unconstrained, some are short hops around a
        // random voxel, and the rest force chosen axes to share the largest
        // delta so that the tie rules and axis-aligned lines keep coming up.
        for (int n = 0; n < N_RANDOM; n++) begin
            kind = $urandom_range(0, 19);
            if (kind < 11) begin
                for (int i = 0; i < lvw_pkg::NUM_AXES; i++) begin
                    st[i] = $urandom_range(0, CMAX);
                    en[i] = $urandom_range(0, CMAX);
                end
            end else if (kind < 15) begin
                for (int i = 0; i < lvw_pkg::NUM_AXES; i++) begin
                    st[i] = $urandom_range(0, CMAX);
                    en[i] = st[i] + $urandom_range(0, 12) - 6;
                    if (en[i] < 0)
                        en[i] = 0;
                    if (en[i] > CMAX)
                        en[i] = CMAX;
                end
            end else begin
                d    = $urandom_range(1, CMAX);
                mask = $urandom_range(1, 7);
                for (int i = 0; i < lvw_pkg::NUM_AXES; i++) begin
                    lo  = $urandom_range(0, CMAX - d);
                    off = mask[i] ? d : $urandom_range(0, d - 1);
                    if ($urandom_range(0, 1)) begin
                        st[i] = lo;
                        en[i] = lo + off;
                    end else begin
                        st[i] = lo + off;
                        en[i] = lo;
                    end
                end
            end
            queue_line(st[lvw_pkg::AXIS_X], st[lvw_pkg::AXIS_Y], st[lvw_pkg::AXIS_Z],
                       en[lvw_pkg::AXIS_X], en[lvw_pkg::AXIS_Y], en[lvw_pkg::AXIS_Z]);
        end

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // A stretch in the middle runs at full rate on both sides, and so
        // does the tail of the run.
        wait (n_accepted >= 200);
        idle_en = 1'b0;
        wait (n_accepted >= 260);
        idle_en = 1'b1;
        wait (n_accepted >= n_lines_total - 60);
        idle_en = 1'b0;

        wait (n_accepted == n_lines_total);
        wait (pending_points.size() == 0);
        // Give a misbehaving block the time of one more full line to show
        // any stray result transactions.
        repeat (70) @(posedge aclk);

        if (n_errors == 0 && pending_points.size() == 0) begin
            $display("tb_line_voxel_walker_3d: PASS");
        end else begin
            $display("tb_line_voxel_walker_3d: FAIL");
        end
        $finish;
    end

endmodule
